>>> src/rgbcv_pkg.sv
// Shared types and constants for the RGB555 converter with frame blending.
// No dependencies.
package rgbcv_pkg;

  localparam int unsigned PIX_W      = 15;
  localparam int unsigned CHAN_W     = 5;
  localparam int unsigned OUT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND  = 2'd1;

  localparam logic [OUT_W-1:0] CLAMP_LEVEL = 8'd240;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } fs_cmd_t;

endpackage

>>> src/rgb555_color_convert_frame_blend.sv
// RGB555 to RGB888 converter with optional previous-frame blending.
// One pixel per cycle while out_ready is high and no frame store clear is running.
// Stages: frame store read, conversion of new and stored pixel, blend/output.
// Reset (synchronous, rst_n low) clears valid flags and config registers and
// starts a clear of all SCREEN_WIDTH*SCREEN_HEIGHT store entries (23040 by default)
// with in_ready low; each write that changes blend_r starts the same clear.
module rgb555_color_convert_frame_blend
  import rgbcv_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 144
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel_color,
  input  logic [PIX_W-1:0]     in_pixel_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_red_out,
  output logic [OUT_W-1:0]     out_green_out,
  output logic [OUT_W-1:0]     out_blue_out
);

  localparam int unsigned PIXEL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned EXT_W  = (ADDR_W > PIX_W) ? ADDR_W : PIX_W;

  logic adjust_r, blend_r;
  logic cfg_we, blend_change;

  fs_cmd_t           fs_cmd;
  logic [EXT_W-1:0]  idx_ext;
  logic [ADDR_W-1:0] fs_addr;
  logic [PIX_W-1:0]  fs_rdata;
  logic              fs_busy;
  logic              in_inside, in_accept;

  logic             s1_v_r, s1_inside_r, s1_blend_r, s1_adjust_r;
  logic [PIX_W-1:0] s1_px_r, s1_old;
  rgb_t             s1_new_rgb, s1_old_rgb;

  logic s2_v_r, s2_blend_r;
  rgb_t s2_new_r, s2_old_r;
  rgb_t s2_avg;
  logic [OUT_W:0] sum_r, sum_g, sum_b;

  logic out_v_r;
  rgb_t out_r;

  logic out_free, s2_free, s1_free, s2_move, s1_move;

  // configuration
  assign cfg_ready    = 1'b1;
  assign cfg_we       = cfg_valid && cfg_ready;
  assign blend_change = cfg_we && (cfg_index == CFG_BLEND) && (cfg_data != blend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adjust_r <= 1'b0;
      blend_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ADJUST) begin
        adjust_r <= cfg_data;
      end
      if (cfg_index == CFG_BLEND) begin
        blend_r <= cfg_data;
      end
    end
  end

  // pipeline flow control
  assign out_free = !out_v_r || out_ready;
  assign s2_free  = !s2_v_r || out_free;
  assign s2_move  = s2_v_r && out_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign s1_move  = s1_v_r && s2_free;
  assign in_ready = s1_free && !fs_busy;
  assign in_accept = in_valid && in_ready;

  // stage 0: frame store access
  assign idx_ext   = EXT_W'(in_pixel_index);
  assign fs_addr   = idx_ext[ADDR_W-1:0];
  assign in_inside = 32'(in_pixel_index) < PIXEL_COUNT;

  assign fs_cmd.rd_en = in_accept && blend_r && in_inside;
  assign fs_cmd.wr_en = in_accept && blend_r && in_inside;
  assign fs_cmd.clear = blend_change;

  rgbcv_frame_store #(
    .DEPTH  (PIXEL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fs_cmd),
    .addr  (fs_addr),
    .wdata (in_pixel_color),
    .rdata (fs_rdata),
    .busy  (fs_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r     <= in_pixel_color;
      s1_inside_r <= in_inside;
      s1_blend_r  <= blend_r;
      s1_adjust_r <= adjust_r;
    end
  end

  // stage 1: convert new and stored pixel
  assign s1_old = (s1_blend_r && s1_inside_r) ? fs_rdata : '0;

  rgbcv_convert u_conv_new (
    .pixel  (s1_px_r),
    .adjust (s1_adjust_r),
    .rgb    (s1_new_rgb)
  );

  rgbcv_convert u_conv_old (
    .pixel  (s1_old),
    .adjust (s1_adjust_r),
    .rgb    (s1_old_rgb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_new_r   <= s1_new_rgb;
      s2_old_r   <= s1_old_rgb;
      s2_blend_r <= s1_blend_r;
    end
  end

  // stage 2: floor average and blend/new select
  assign sum_r = {1'b0, s2_new_r.red}   + {1'b0, s2_old_r.red};
  assign sum_g = {1'b0, s2_new_r.green} + {1'b0, s2_old_r.green};
  assign sum_b = {1'b0, s2_new_r.blue}  + {1'b0, s2_old_r.blue};

  assign s2_avg.red   = sum_r[OUT_W:1];
  assign s2_avg.green = sum_g[OUT_W:1];
  assign s2_avg.blue  = sum_b[OUT_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_r <= s2_blend_r ? s2_avg : s2_new_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_red_out   = out_r.red;
  assign out_green_out = out_r.green;
  assign out_blue_out  = out_r.blue;

endmodule

>>> src/rgbcv_convert.sv
// RGB555 to RGB888 channel conversion: plain expansion or correction matrix.
// Depends on rgbcv_pkg.
module rgbcv_convert
  import rgbcv_pkg::*;
(
  input  logic [PIX_W-1:0] pixel,
  input  logic             adjust,
  output rgb_t             rgb
);

  logic [CHAN_W-1:0] r, g, b;
  logic [9:0]        sum_r, sum_g, sum_b;
  logic [OUT_W-1:0]  q_r, q_g, q_b;

  assign r = pixel[4:0];
  assign g = pixel[9:5];
  assign b = pixel[14:10];

  // max of each sum is 992, fits 10 bits
  assign sum_r = 10'(r) * 10'd26 + 10'(g) * 10'd4 + 10'(b) * 10'd2;
  assign sum_g = 10'(g) * 10'd24 + 10'(b) * 10'd8;
  assign sum_b = 10'(r) * 10'd6 + 10'(g) * 10'd4 + 10'(b) * 10'd22;

  assign q_r = sum_r[9:2];
  assign q_g = sum_g[9:2];
  assign q_b = sum_b[9:2];

  always_comb begin
    if (adjust) begin
      rgb.red   = (q_r > CLAMP_LEVEL) ? CLAMP_LEVEL : q_r;
      rgb.green = (q_g > CLAMP_LEVEL) ? CLAMP_LEVEL : q_g;
      rgb.blue  = (q_b > CLAMP_LEVEL) ? CLAMP_LEVEL : q_b;
    end else begin
      rgb.red   = {r, r[4:2]};
      rgb.green = {g, g[4:2]};
      rgb.blue  = {b, b[4:2]};
    end
  end

endmodule

>>> src/rgbcv_frame_store.sv
// Previous-frame pixel memory with a one-entry-per-cycle clearing pass.
// Depends on rgbcv_pkg.
module rgbcv_frame_store
  import rgbcv_pkg::*;
#(
  parameter int unsigned DEPTH  = 23040,
  parameter int unsigned ADDR_W = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fs_cmd_t           cmd,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]  rdata,
  output logic              busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rdata_r;
  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              wr;
  logic [ADDR_W-1:0] waddr;
  logic [PIX_W-1:0]  wval;

  always_comb begin
    busy_nxt     = busy_r;
    clr_addr_nxt = clr_addr_r;
    if (cmd.clear) begin
      busy_nxt     = 1'b1;
      clr_addr_nxt = '0;
    end else if (busy_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        busy_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign wr    = busy_r || cmd.wr_en;
  assign waddr = busy_r ? clr_addr_r : addr;
  assign wval  = busy_r ? '0 : wdata;

  // read-first: same-address write returns the old entry
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[waddr] <= wval;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

>>> src/rgbcv_checker.sv
// Port-level checks for rgb555_color_convert_frame_blend, bound to the top level.
// Depends on rgbcv_pkg.
module rgbcv_checker
  import rgbcv_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 cfg_data,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [PIX_W-1:0]     in_pixel_color,
  input logic [PIX_W-1:0]     in_pixel_index,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_W-1:0]     out_red_out,
  input logic [OUT_W-1:0]     out_green_out,
  input logic [OUT_W-1:0]     out_blue_out
);

  logic blend_r;
  logic blend_wr;

  assign blend_wr = cfg_valid && cfg_ready && (cfg_index == CFG_BLEND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_r <= 1'b0;
    end else if (blend_wr) begin
      blend_r <= cfg_data;
    end
  end

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // reset starts a frame store clear
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready right after reset");

  // a blend mode change blocks input while the store clears
  a_blend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (blend_wr && (cfg_data != blend_r)) |=> !in_ready)
    else $error("input taken during frame store clear");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_red_out)
      && $stable(out_green_out) && $stable(out_blue_out)))
    else $error("output beat changed while stalled");

endmodule

bind rgb555_color_convert_frame_blend rgbcv_checker u_chk (.*);

>>> tb/testbench.sv
// Self-checking testbench for rgb555_color_convert_frame_blend.
// Predicts each RGB888 beat from its own frame store copy; needs rgbcv_pkg and the block.
`timescale 1ns / 100ps

module testbench;
  import rgbcv_pkg::*;

  localparam int SCREEN_WIDTH  = 160;
  localparam int SCREEN_HEIGHT = 144;
  localparam int FRAME_PIXELS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int PIPE_LATENCY  = 3;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_PRINTS    = 200;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  class blend_predictor;
    bit                color_matrix_on;
    bit                blend_on;
    bit [PIX_W-1:0]    prior_frame [FRAME_PIXELS];
    rgb_t              expected_rgb [$];
    int                mismatches;

    function void clear_frame();
      foreach (prior_frame[k]) prior_frame[k] = '0;
    endfunction

    function void reset_state();
      color_matrix_on = 1'b0;
      blend_on = 1'b0;
      clear_frame();
      expected_rgb.delete();
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic val);
      if (idx == CFG_ADJUST) begin
        color_matrix_on = val;
      end else if (idx == CFG_BLEND) begin
        if (val != blend_on) begin
          blend_on = val;
          clear_frame();
        end
      end
    endfunction

    function rgb_t to_rgb888(bit [PIX_W-1:0] px);
      int unsigned r, g, b, rr, gg, bb;
      rgb_t o;
      r = 32'(px[4:0]);
      g = 32'(px[9:5]);
      b = 32'(px[14:10]);
      if (color_matrix_on) begin
        rr = (r * 26 + g * 4 + b * 2) >> 2;
        gg = (g * 24 + b * 8) >> 2;
        bb = (r * 6 + g * 4 + b * 22) >> 2;
        o.red   = (rr > CLAMP_LEVEL) ? CLAMP_LEVEL : rr[OUT_W-1:0];
        o.green = (gg > CLAMP_LEVEL) ? CLAMP_LEVEL : gg[OUT_W-1:0];
        o.blue  = (bb > CLAMP_LEVEL) ? CLAMP_LEVEL : bb[OUT_W-1:0];
      end else begin
        o.red   = {px[4:0], px[4:2]};
        o.green = {px[9:5], px[9:7]};
        o.blue  = {px[14:10], px[14:12]};
      end
      return o;
    endfunction

    function rgb_t mean_rgb(rgb_t a, rgb_t b);
      int unsigned rr, gg, bb;
      rgb_t o;
      rr = (int'(a.red) + int'(b.red)) >> 1;
      gg = (int'(a.green) + int'(b.green)) >> 1;
      bb = (int'(a.blue) + int'(b.blue)) >> 1;
      o.red   = rr[OUT_W-1:0];
      o.green = gg[OUT_W-1:0];
      o.blue  = bb[OUT_W-1:0];
      return o;
    endfunction

    function void take_pixel(bit [PIX_W-1:0] color, bit [PIX_W-1:0] index);
      rgb_t fresh;
      bit [PIX_W-1:0] old;
      fresh = to_rgb888(color);
      if (blend_on) begin
        old = (index < FRAME_PIXELS) ? prior_frame[index] : '0;
        fresh = mean_rgb(to_rgb888(old), fresh);
        if (index < FRAME_PIXELS) prior_frame[index] = color;
      end
      expected_rgb.push_back(fresh);
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTS) $display("%0t MISMATCH %s", $realtime, msg);
      mismatches++;
    endtask

    task check_pixel(logic [OUT_W-1:0] red, logic [OUT_W-1:0] green, logic [OUT_W-1:0] blue);
      rgb_t want;
      if (expected_rgb.size() == 0) begin
        report($sformatf("unexpected beat r=%0d g=%0d b=%0d", red, green, blue));
      end else begin
        want = expected_rgb.pop_front();
        if (red !== want.red)
          report($sformatf("red got %0d want %0d", red, want.red));
        if (green !== want.green)
          report($sformatf("green got %0d want %0d", green, want.green));
        if (blue !== want.blue)
          report($sformatf("blue got %0d want %0d", blue, want.blue));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_color;
  logic [PIX_W-1:0]     in_pixel_index;
  logic                 out_valid;
  logic                 out_ready;
  logic [OUT_W-1:0]     out_red_out;
  logic [OUT_W-1:0]     out_green_out;
  logic [OUT_W-1:0]     out_blue_out;

  blend_predictor sb;
  int             rx_stall_max = 0;
  int             tx_gap_max = 0;
  int             hold_requests = 0;
  int unsigned    cycle_count = 0;
  logic [PIX_W-1:0] corner_colors [5] = '{15'h0000, 15'h7FFF, 15'h001F, 15'h03E0, 15'h7C00};

  rgb555_color_convert_frame_blend #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_color(in_pixel_color),
    .in_pixel_index(in_pixel_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rgb555_color_convert_frame_blend verification failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] color, input logic [PIX_W-1:0] index,
                            input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_color <= color;
    in_pixel_index <= index;
    do @(posedge clk); while (!in_ready);
    sb.take_pixel(color, index);
  endtask

  task automatic stop_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain the pipeline and any store clear before touching registers
  task automatic settle();
    stop_pixels();
    while (sb.expected_rgb.size() != 0 || !in_ready) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_served;
    stall_left = 0;
    hold_left = 0;
    holds_served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_pixel(out_red_out, out_green_out, out_blue_out);
        stall_left = $urandom_range(0, rx_stall_max);
      end
    end
  end

  initial begin : pixel_source
    logic [PIX_W-1:0] color;
    logic [PIX_W-1:0] index;
    logic [PIX_W-1:0] last_index;
    sb = new();
    sb.reset_state();
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_ADJUST;
    cfg_data       = 1'b0;
    in_valid       = 1'b0;
    in_pixel_color = '0;
    in_pixel_index = '0;
    last_index     = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: plain expansion, frame edges and out-of-frame index
    settle();
    send_pixel(15'h0000, 15'd0, 0);
    send_pixel(15'h7FFF, PIX_W'(FRAME_PIXELS - 1), 0);
    send_pixel(15'h001F, PIX_W'(FRAME_PIXELS), 0);
    send_pixel(15'h03E0, 15'h7FFF, 0);
    send_pixel(15'h7C00, 15'd1, 0);
    send_pixel(15'h5555, 15'h2AAA, 0);
    // correction matrix with clamping
    settle();
    write_reg(CFG_ADJUST, 1'b1);
    send_pixel(15'h7FFF, 15'd2, 0);
    send_pixel(15'h001F, 15'd2, 0);
    send_pixel(15'h03E0, 15'd3, 0);
    send_pixel(15'h7C00, 15'd4, 0);
    // blending: same index back to back, out of frame
    settle();
    write_reg(CFG_BLEND, 1'b1);
    send_pixel(15'h7FFF, 15'd5, 0);
    send_pixel(15'h1234, 15'd5, 0);
    send_pixel(15'h4321, 15'h7FFF, 0);
    send_pixel(15'h0ABC, PIX_W'(FRAME_PIXELS - 1), 0);
    // rewrite blend with same value, color mode change, spare registers: store kept
    settle();
    write_reg(CFG_BLEND, 1'b1);
    write_reg(CFG_ADJUST, 1'b0);
    write_reg(CFG_SPARE2, 1'b1);
    write_reg(CFG_SPARE3, 1'b1);
    send_pixel(15'h0000, 15'd5, 0);
    send_pixel(15'h7FFF, PIX_W'(FRAME_PIXELS - 1), 0);
    // blend off then on: store cleared
    settle();
    write_reg(CFG_BLEND, 1'b0);
    settle();
    write_reg(CFG_BLEND, 1'b1);
    send_pixel(15'h2222, 15'd5, 0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(CFG_ADJUST, p[0]);
      write_reg(CFG_BLEND, p[1]);
      write_reg(p[2] ? CFG_SPARE2 : CFG_SPARE3, 1'($urandom_range(0, 1)));
      tx_gap_max   = (p % 3 == 0) ? 0 : 15;
      rx_stall_max = (p % 4 == 0) ? 0 : 15;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 60) hold_requests++;
        if (p == 2 && n == 100) begin
          stop_pixels();
          while (sb.expected_rgb.size() != 0) @(negedge clk);
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: index = PIX_W'($urandom_range(0, 31));
          6, 7:             index = PIX_W'($urandom_range(0, FRAME_PIXELS - 1));
          8:                index = PIX_W'($urandom_range(FRAME_PIXELS, 32767));
          default:          index = last_index;
        endcase
        color = ($urandom_range(0, 7) == 0) ? corner_colors[3'($urandom_range(0, 4))]
                                            : PIX_W'($urandom_range(0, 32767));
        last_index = index;
        send_pixel(color, index, $urandom_range(0, tx_gap_max));
      end
    end

    stop_pixels();
    while (sb.expected_rgb.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 5) @(negedge clk);
    if (sb.expected_rgb.size() != 0)
      sb.report($sformatf("%0d beats never arrived", sb.expected_rgb.size()));
    if (sb.mismatches == 0) begin
      $display("rgb555_color_convert_frame_blend verification clean");
    end else begin
      $display("rgb555_color_convert_frame_blend verification failed");
    end
    $finish;
  end

endmodule
